// File: hdl/veia_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// veia_pkg: shared types and constants of the entity handle allocator
// Transaction payloads, operation and status codes, and the command and
// status groups between controller and datapath.
// ---------------------------------------------------------------------------
package veia_pkg;

    localparam int MAX_ENTITIES_DEF  = 1024;
    localparam int VERSION_SHIFT_DEF = 20;

    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_FREE   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [1:0] STAT_OK           = 2'd0;
    localparam logic [1:0] STAT_EXHAUSTED    = 2'd1;
    localparam logic [1:0] STAT_NEVER_ISSUED = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] handle_in;
    } t_alloc_req;

    typedef struct packed {
        logic [31:0] handle_out;
        logic [1:0]  status;
    } t_alloc_rsp;

    typedef struct packed {
        logic       capture;
        logic       pop;
        logic       fresh;
        logic       push;
        logic       wipe;
        logic       finish;
        logic [1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       list_empty;
        logic       fresh_ok;
        logic       id_issued;
    } t_dp_stat;

endpackage
`default_nettype wire

// File: hdl/veia_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// veia_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module veia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: hdl/veia_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// veia_datapath: entity table, free list head and identifier counters
// Reads the table slot at capture and carries out the update that the
// controller commands in the following cycle.
// ---------------------------------------------------------------------------
module veia_datapath
    import veia_pkg::*;
#(
    parameter int MAX_ENTITIES  = MAX_ENTITIES_DEF,
    parameter int VERSION_SHIFT = VERSION_SHIFT_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_alloc_req i_req,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_stat        o_stat,
    output t_alloc_rsp      o_rsp
);

    localparam int AW = $clog2(MAX_ENTITIES);
    localparam int CW = $clog2(MAX_ENTITIES + 1);
    localparam logic [31:0] ID_MASK     = 32'((64'(1) << VERSION_SHIFT) - 64'(1));
    localparam logic [31:0] VERSION_ONE = 32'(64'(1) << VERSION_SHIFT);
    localparam logic [31:0] ID_SPAN     = 32'(64'(1) << VERSION_SHIFT);
    localparam logic [31:0] MAX_W       = 32'(MAX_ENTITIES);
    // Fresh identifiers stop at the table size or the identifier range.
    localparam logic [31:0] FRESH_LIMIT = (MAX_W < ID_SPAN) ? MAX_W : ID_SPAN;

    t_alloc_req  r_req;
    logic [AW-1:0] r_slot;
    logic [31:0] r_free_head, n_free_head;
    logic [CW-1:0] r_free_count, n_free_count;
    logic [CW-1:0] r_next_fresh, n_next_fresh;
    t_alloc_rsp  r_rsp, n_rsp;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    function automatic logic [AW-1:0] slot_of(input logic [31:0] handle);
        logic [31:0] id;
        id = handle & ID_MASK;
        return (id < MAX_W) ? id[AW-1:0] : '0;
    endfunction

    // Free reads the slot of the given identifier, create the slot of the list head.
    assign ram_raddr = (i_req.mode == MODE_FREE) ? slot_of(i_req.handle_in)
                                                 : slot_of(r_free_head);

    veia_ram #(
        .WIDTH (32),
        .DEPTH (MAX_ENTITIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_stat.mode       = r_req.mode;
        o_stat.list_empty = (r_free_count == '0);
        o_stat.fresh_ok   = (32'(r_next_fresh) < FRESH_LIMIT);
        o_stat.id_issued  = ((r_req.handle_in & ID_MASK) < 32'(r_next_fresh));
    end

    always_comb begin
        n_free_head  = r_free_head;
        n_free_count = r_free_count;
        n_next_fresh = r_next_fresh;
        n_rsp        = r_rsp;
        ram_we       = 1'b0;
        ram_waddr    = r_slot;
        ram_wdata    = r_free_head;
        if (i_cmd.pop) begin
            ram_we       = 1'b1;
            n_free_head  = ram_rdata;
            n_free_count = r_free_count - CW'(1);
        end
        if (i_cmd.fresh) begin
            ram_we       = 1'b1;
            ram_waddr    = r_next_fresh[AW-1:0];
            ram_wdata    = 32'(r_next_fresh);
            n_next_fresh = r_next_fresh + CW'(1);
        end
        if (i_cmd.push) begin
            // The slot takes the old head as its link; the bumped handle becomes the head.
            ram_we      = 1'b1;
            n_free_head = ram_rdata + VERSION_ONE;
            if (r_free_count < CW'(MAX_ENTITIES)) begin
                n_free_count = r_free_count + CW'(1);
            end
        end
        if (i_cmd.wipe) begin
            n_free_head  = '1;
            n_free_count = '0;
            n_next_fresh = '0;
        end
        if (i_cmd.finish) begin
            n_rsp.status = i_cmd.status;
            if (i_cmd.pop) begin
                n_rsp.handle_out = r_free_head;
            end else if (i_cmd.fresh) begin
                n_rsp.handle_out = 32'(r_next_fresh);
            end else begin
                n_rsp.handle_out = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head  <= '1;
            r_free_count <= '0;
            r_next_fresh <= '0;
        end else begin
            r_free_head  <= n_free_head;
            r_free_count <= n_free_count;
            r_next_fresh <= n_next_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= i_req;
            r_slot <= ram_raddr;
        end
        r_rsp <= n_rsp;
    end

    assign o_rsp = r_rsp;

endmodule
`default_nettype wire

// File: hdl/veia_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// veia_ctrl: transaction sequencer of the entity handle allocator
// Captures a transaction, then chooses the table update and the status.
// ---------------------------------------------------------------------------
module veia_ctrl
    import veia_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_busy,
    output logic          o_done
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_UPDATE = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_done;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.status   = STAT_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
                unique case (i_stat.mode)
                    MODE_CREATE: begin
                        if (!i_stat.list_empty) begin
                            o_cmd.pop = 1'b1;
                        end else if (i_stat.fresh_ok) begin
                            o_cmd.fresh = 1'b1;
                        end else begin
                            o_cmd.status = STAT_EXHAUSTED;
                        end
                    end
                    MODE_FREE: begin
                        if (i_stat.id_issued) begin
                            o_cmd.push = 1'b1;
                        end else begin
                            o_cmd.status = STAT_NEVER_ISSUED;
                        end
                    end
                    MODE_CLEAR: begin
                        o_cmd.wipe = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.finish;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule
`default_nettype wire

// File: hdl/versioned_entity_id_allocator.sv
`default_nettype none
// ---------------------------------------------------------------------------
// versioned_entity_id_allocator: versioned entity handle allocator
// Issues and recycles 32-bit handles through a free list kept in the table.
// ---------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. It has a
// capture step, which reads one entity table slot from the registered-read
// table RAM, and an update step, which makes the table write that the
// operation needs, if any, and updates the free list head and counters.
// The result appears on o_rsp with o_done high for exactly one cycle,
// registered from the update step; it must be taken in that cycle, as the
// block cannot hold it. busy is already low in that cycle, so a new
// transaction may be accepted then, though never during an update.
// The table needs no clearing pass after reset or clear.
module versioned_entity_id_allocator
    import veia_pkg::*;
#(
    parameter int MAX_ENTITIES  = MAX_ENTITIES_DEF,
    parameter int VERSION_SHIFT = VERSION_SHIFT_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire t_alloc_req i_req,
    output logic            busy,
    output logic            o_done,
    output t_alloc_rsp      o_rsp
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    veia_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    veia_datapath #(
        .MAX_ENTITIES  (MAX_ENTITIES),
        .VERSION_SHIFT (VERSION_SHIFT)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_rsp   (o_rsp)
    );

endmodule
`default_nettype wire

// File: hdl/veia_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// veia_checker: port-level checks of the entity handle allocator
// Timing of transactions and results as seen on the top-level ports.
// ---------------------------------------------------------------------------
module veia_checker
    import veia_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_done,
    input wire t_alloc_rsp o_rsp
);

    // An accepted transaction holds the block busy for its update state alone.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy ##1 !busy)
        else $error("busy did not follow an accepted transaction");

    // Every accepted transaction gives its result strobe, registered after its update state.
    a_result_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("result strobe missing after a transaction");

    // A result never appears while a transaction is still at work.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $past(busy))
        else $error("result strobe outside the end of a transaction");

    // Failed operations return a zero handle and a defined status.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != STAT_OK) |->
            (o_rsp.handle_out == '0) &&
            (o_rsp.status == STAT_EXHAUSTED || o_rsp.status == STAT_NEVER_ISSUED))
        else $error("failed transaction returned a handle or a bad status");

endmodule

bind versioned_entity_id_allocator veia_checker u_veia_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
`default_nettype wire

// File: tb/versioned_entity_id_allocator_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// versioned_entity_id_allocator_test: self-checking bench for the allocator
// A queue of commands feeds a clocked driver with no gaps or random gaps
// between transactions. An in-bench model of the handle table and free
// list predicts every response. A clocked monitor compares each strobed
// response, field by field, against the oldest prediction.
// ---------------------------------------------------------------------------
module versioned_entity_id_allocator_test;
    import veia_pkg::*;

    localparam int unsigned MAX_IDS     = MAX_ENTITIES_DEF;
    localparam int unsigned ID_MASK     = (1 << VERSION_SHIFT_DEF) - 1;
    localparam logic [31:0] VERSION_INC = 32'(1) << VERSION_SHIFT_DEF;

    typedef struct {
        t_alloc_req  req;
        int unsigned gap;
    } t_alloc_cmd;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    t_alloc_req i_req   = '0;
    logic       busy;
    logic       o_done;
    t_alloc_rsp o_rsp;

    t_alloc_cmd  cmd_backlog[$];
    t_alloc_rsp  awaited_rsp_q[$];
    int unsigned gap_style  = 0;
    int unsigned idle_wait  = 0;
    int unsigned fail_count = 0;
    int unsigned rsp_seen   = 0;

    // Predicted allocator state.
    logic [31:0] slot_mem[MAX_IDS];
    logic [31:0] list_top  = '1;
    int unsigned list_len  = 0;
    int unsigned fresh_id  = 0;

    // Tallies for the closing summary.
    int unsigned n_issued    = 0;
    int unsigned n_exhausted = 0;
    int unsigned n_unissued  = 0;
    int unsigned n_freed     = 0;
    int unsigned n_saturated = 0;
    int unsigned n_wiped     = 0;

    versioned_entity_id_allocator dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // Advances the free-list model by one transaction and returns its response.
    function automatic t_alloc_rsp alloc_outcome(input t_alloc_req req);
        t_alloc_rsp  rsp;
        logic [31:0] popped;
        logic [31:0] bumped;
        int unsigned slot;
        int unsigned id;
        rsp = '0;
        case (req.mode)
            MODE_CREATE: begin
                if (list_len > 0) begin
                    popped = list_top;
                    // Identifiers beyond the table fold onto slot zero.
                    slot = ((popped & ID_MASK) < MAX_IDS) ? (popped & ID_MASK) : 0;
                    list_top = slot_mem[slot];
                    slot_mem[slot] = popped;
                    list_len--;
                    rsp.handle_out = popped;
                    n_issued++;
                end else if (fresh_id < MAX_IDS && fresh_id <= ID_MASK) begin
                    rsp.handle_out = 32'(fresh_id);
                    slot_mem[fresh_id] = 32'(fresh_id);
                    fresh_id++;
                    n_issued++;
                end else begin
                    rsp.status = STAT_EXHAUSTED;
                    n_exhausted++;
                end
            end
            MODE_FREE: begin
                id = req.handle_in & ID_MASK;
                if (id >= fresh_id) begin
                    rsp.status = STAT_NEVER_ISSUED;
                    n_unissued++;
                end else begin
                    // The stored version is bumped; the caller's version is ignored.
                    bumped = slot_mem[id] + VERSION_INC;
                    slot_mem[id] = list_top;
                    list_top = bumped;
                    if (list_len < MAX_IDS) begin
                        list_len++;
                    end else begin
                        n_saturated++;
                    end
                    n_freed++;
                end
            end
            MODE_CLEAR: begin
                foreach (slot_mem[i]) slot_mem[i] = '0;
                list_top = '1;
                list_len = 0;
                fresh_id = 0;
                n_wiped++;
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    task automatic add_cmd(input logic [1:0] mode, input logic [31:0] handle);
        t_alloc_cmd cmd;
        cmd.req.mode      = mode;
        cmd.req.handle_in = handle;
        case (gap_style)
            0: cmd.gap = 0;
            1: cmd.gap = $urandom_range(0, 7);
            default: cmd.gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 7) : 0;
        endcase
        cmd_backlog.insert(cmd_backlog.size(), cmd);
    endtask

    // A session starts from a clear and mixes creates with frees of mostly
    // issued identifiers, plus frees of unissued ones and unused modes.
    task automatic mixed_session(input int unsigned n_cmds);
        int unsigned made;
        int unsigned pick;
        made = 0;
        add_cmd(MODE_CLEAR, $urandom);
        repeat (n_cmds) begin
            pick = $urandom_range(0, 99);
            if (pick < 50 || made == 0) begin
                add_cmd(MODE_CREATE, $urandom);
                made++;
            end else if (pick < 88) begin
                add_cmd(MODE_FREE, ($urandom & ~ID_MASK) | 32'($urandom_range(0, made - 1)));
            end else if (pick < 93) begin
                add_cmd(MODE_FREE, $urandom);
            end else if (pick < 97) begin
                add_cmd(MODE_FREE, ($urandom & ~ID_MASK) | 32'(made));
            end else begin
                add_cmd(MODE_NONE, $urandom);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            idle_wait = 0;
        end else if (start && !busy) begin
            awaited_rsp_q.insert(awaited_rsp_q.size(), alloc_outcome(i_req));
            idle_wait = 0;
            if (cmd_backlog.size() > 0 && cmd_backlog[0].gap == 0) begin
                i_req <= cmd_backlog[0].req;
                void'(cmd_backlog.pop_front());
            end else begin
                start <= 1'b0;
            end
        end else if (!start && cmd_backlog.size() > 0) begin
            if (idle_wait < cmd_backlog[0].gap) begin
                idle_wait++;
            end else begin
                start <= 1'b1;
                i_req <= cmd_backlog[0].req;
                void'(cmd_backlog.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin : check_rsp
        t_alloc_rsp due;
        if (i_rst_n && o_done !== 1'b0) begin
            if (awaited_rsp_q.size() == 0) begin
                $error("response with no transaction outstanding: handle_out %h status %0d",
                       o_rsp.handle_out, o_rsp.status);
                fail_count++;
            end else begin
                due = awaited_rsp_q.pop_front();
                rsp_seen++;
                if (o_rsp.handle_out !== due.handle_out) begin
                    $error("handle_out: expected %h, got %h", due.handle_out, o_rsp.handle_out);
                    fail_count++;
                end
                if (o_rsp.status !== due.status) begin
                    $error("status: expected %0d, got %0d", due.status, o_rsp.status);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        // Directed opening: fresh issue, stale and unissued frees, double
        // frees, list pops, unused mode and clear.
        gap_style = 1;
        add_cmd(MODE_CREATE, 32'h0000_0000);
        add_cmd(MODE_CREATE, 32'hFFFF_FFFF);
        add_cmd(MODE_CREATE, 32'h0000_0000);
        add_cmd(MODE_FREE,   32'hFFF0_0001);
        add_cmd(MODE_FREE,   32'h0000_0001);
        add_cmd(MODE_FREE,   32'hFFFF_FFFF);
        add_cmd(MODE_FREE,   32'h0000_0003);
        add_cmd(MODE_FREE,   32'h0000_0000);
        add_cmd(MODE_FREE,   32'h0000_0000);
        repeat (6) add_cmd(MODE_CREATE, 32'hFFFF_FFFF);
        add_cmd(MODE_NONE,   32'hFFFF_FFFF);
        add_cmd(MODE_NONE,   32'h0000_0000);
        add_cmd(MODE_CLEAR,  32'hFFFF_FFFF);
        add_cmd(MODE_FREE,   32'h0000_0000);
        add_cmd(MODE_CREATE, 32'h0000_0000);
        add_cmd(MODE_FREE,   32'h0000_0000);
        add_cmd(MODE_CREATE, 32'h0000_0000);
        add_cmd(MODE_CLEAR,  32'h0000_0000);

        for (int s = 0; s < 6; s++) begin
            gap_style = s % 3;
            mixed_session($urandom_range(40, 80));
        end

        // Fill the table to exhaustion, then free past the list capacity so
        // the count saturates, then pop some handles back out.
        gap_style = 2;
        add_cmd(MODE_CLEAR, $urandom);
        repeat (MAX_IDS + 3) add_cmd(MODE_CREATE, $urandom);
        repeat (MAX_IDS + 6) begin
            add_cmd(MODE_FREE, ($urandom & ~ID_MASK) | 32'($urandom_range(0, MAX_IDS - 1)));
        end
        repeat (40) add_cmd(MODE_CREATE, $urandom);

        gap_style = 1;
        mixed_session(60);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() > 0 || start || awaited_rsp_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        $display("%0d responses checked: %0d handles issued, %0d exhausted creates,",
                 rsp_seen, n_issued, n_exhausted);
        $display("%0d frees, %0d of unissued identifiers, %0d past list capacity, %0d clears",
                 n_freed, n_unissued, n_saturated, n_wiped);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
